/* sv/pd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_pkg: shared types and codes for the priority dispatcher
// Beat layouts for commands and results, the stored table entry and the
// control group of the shared priority compare unit.
// ----------------------------------------------------------------------------
package pd_pkg;

  // Command codes
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  // Result event codes
  localparam logic [2:0] EV_ACCEPTED   = 3'd0;
  localparam logic [2:0] EV_FULL       = 3'd1;
  localparam logic [2:0] EV_STARTED    = 3'd2;
  localparam logic [2:0] EV_TERMINATED = 3'd3;
  localparam logic [2:0] EV_EMPTY      = 3'd4;

  typedef struct packed {
    logic        op;
    logic [15:0] pid;
    logic [7:0]  prio;
    logic [15:0] cpu_time;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] out_pid;
    logic [7:0]  out_prio;
    logic [31:0] stamp;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] pid;
    logic [7:0]  prio;
    logic [15:0] cpu_time;
  } entry_t;

  // Control of the compare unit: a read beat arrives, and whether it is
  // the first entry of the scan.
  typedef struct packed {
    logic sample;
    logic first;
  } scan_ctl_t;

endpackage

/* sv/pd_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_table: ready table storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module pd_table
  import pd_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/pd_pick.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pd_pick: shared priority compare unit
// Keeps the best entry seen so far in a scan; on equal priority the later
// entry wins.
// ----------------------------------------------------------------------------
module pd_pick
  import pd_pkg::*;
#(
  parameter int AW = 6
) (
  input  logic          clk,
  input  scan_ctl_t     ctl,
  input  logic [AW-1:0] idx,
  input  entry_t        entry,
  output entry_t        best,
  output logic [AW-1:0] best_idx
);

  logic take;

  assign take = ctl.sample && (ctl.first || (entry.prio >= best.prio));

  always_ff @(posedge clk) begin
    if (take) begin
      best     <= entry;
      best_idx <= idx;
    end
  end

endmodule

/* sv/priority_dispatcher_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_dispatcher_core: non-preemptive priority ready table
// Add commands append a process; dispatch commands remove the entry of
// highest priority and report its start and termination times.
// ----------------------------------------------------------------------------
// Add, or dispatch on an empty table: one result beat in the cycle after the
// command is taken; busy stays low, so such commands may follow every cycle.
// Dispatch with entries held: a read scan over all of them, a settle step and a
// locate step, then moves of the entries above the chosen one and a drain step
// when it was not the last, then the started and terminated beats.
// Synchronous reset empties the table and clears the clock; no result stalls.
// ----------------------------------------------------------------------------
module priority_dispatcher_core
  import pd_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    strobe,
  output result_t result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SCAN   = 8'b0000_0010,
    S_SETTLE = 8'b0000_0100,
    S_LOCATE = 8'b0000_1000,
    S_MOVE   = 8'b0001_0000,
    S_DRAIN  = 8'b0010_0000,
    S_START  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [31:0]   clock_now;
  logic [AW-1:0] ptr;
  logic [AW-1:0] idx_d;
  logic          sample;
  logic          pend;
  logic [AW-1:0] pend_addr;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  entry_t        rdata;
  entry_t        best;
  logic [AW-1:0] best_idx;
  scan_ctl_t     scan_ctl;
  logic [AW-1:0] count_m1;
  logic          full;
  logic          add_ok;
  logic [31:0]   finish;

  assign busy     = (state != S_IDLE);
  assign count_m1 = AW'(count - CW'(1));
  assign full     = (count == CW'(DEPTH));
  assign finish   = clock_now + 32'(best.cpu_time);

  // An accepted add writes straight from the command beat; during
  // compaction the write port is fed from the read data in the cycle after
  // the read address.
  assign add_ok = (state == S_IDLE) && start && (item.op == OP_ADD) && !full;
  assign we     = add_ok || pend;
  assign waddr  = pend ? pend_addr : count[AW-1:0];
  assign wdata  = pend ? rdata : entry_t'{item.pid, item.prio, item.cpu_time};

  assign scan_ctl.sample = sample;
  assign scan_ctl.first  = (idx_d == '0);

  pd_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr),
    .rdata (rdata)
  );

  pd_pick #(
    .AW (AW)
  ) u_pick (
    .clk      (clk),
    .ctl      (scan_ctl),
    .idx      (idx_d),
    .entry    (rdata),
    .best     (best),
    .best_idx (best_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      clock_now <= '0;
      strobe    <= 1'b0;
      pend      <= 1'b0;
      sample    <= 1'b0;
    end else begin
      strobe    <= 1'b0;
      pend      <= (state == S_MOVE);
      sample    <= (state == S_SCAN);
      idx_d     <= ptr;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (item.op == OP_ADD) begin
              strobe <= 1'b1;
              result <= result_t'{(full ? EV_FULL : EV_ACCEPTED), item.pid,
                                  item.prio, clock_now, 1'b1};
              if (!full) begin
                count <= count + CW'(1);
              end
            end else if (count == '0) begin
              strobe <= 1'b1;
              result <= result_t'{EV_EMPTY, 16'd0, 8'd0, clock_now, 1'b1};
            end else begin
              ptr   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Read one entry per cycle; the compare unit sees it in the next cycle.
          if (ptr == count_m1) begin
            state <= S_SETTLE;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_SETTLE: begin
          state <= S_LOCATE;
        end
        S_LOCATE: begin
          // Nothing to close up when the chosen entry was the last one.
          if (best_idx == count_m1) begin
            state <= S_START;
          end else begin
            ptr   <= best_idx + AW'(1);
            state <= S_MOVE;
          end
        end
        S_MOVE: begin
          pend_addr <= ptr - AW'(1);
          if (ptr == count_m1) begin
            state <= S_DRAIN;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_START;
        end
        S_START: begin
          strobe <= 1'b1;
          result <= result_t'{EV_STARTED, best.pid, best.prio, clock_now, 1'b0};
          count  <= count - CW'(1);
          state  <= S_FINISH;
        end
        S_FINISH: begin
          strobe    <= 1'b1;
          result    <= result_t'{EV_TERMINATED, best.pid, best.prio, finish, 1'b1};
          clock_now <= finish;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the table size.
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond table size");

  // An add command always answers with a single final beat next cycle.
  a_add_answer : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.op == OP_ADD) |=> (strobe && result.last))
    else $error("add command without final result beat");

  // A started beat is always followed at once by the terminated beat.
  a_start_pair : assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |=> (strobe && result.event_res == EV_TERMINATED))
    else $error("started beat not followed by terminated beat");

  // Compaction only moves entries above the chosen one.
  a_move_above : assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) |-> (ptr > best_idx))
    else $error("compaction read below chosen entry");

endmodule
